/* sv/mtei_pkg.sv */
`timescale 1ns / 1ps

package mtei_pkg;

  // table geometry
  localparam int MaxBits  = 8;
  localparam int IdxW     = MaxBits;
  localparam int TblDepth = 1 << MaxBits;
  localparam int AbW      = 4;

  // field widths
  localparam int CoeffW = 32;
  localparam int SumW   = 40;
  localparam int PointW = 8;

  typedef enum logic [1:0] {
    OpWrite   = 2'd0,
    OpEval    = 2'd1,
    OpInverse = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    StIdle,
    StWalk,
    StDrain,
    StFinish
  } state_e;

endpackage

/* sv/moment_table_eval_and_inverse_top.sv */
`timescale 1ns / 1ps
// a write gives no result; an evaluate walks the active table of size = 2^min(active_bits, 8)
//   entries (one table entry per cycle), then drains and registers its result
// an inverse repeats that walk once per search step, min(active_bits, 8) steps;
//   with active_bits zero its result follows in the cycle after start
// busy drops with the result strobe, so the next item can start in that cycle
// reset clears the table (per-entry valid flops) and sets active_bits to 8; no result stall
module moment_table_eval_and_inverse_top import mtei_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               opcode_i,
  input  logic [7:0]               entry_index_i,
  input  logic signed [CoeffW-1:0] coeff_value_i,
  input  logic [PointW-1:0]        point_i,
  input  logic signed [31:0]       target_i,
  input  logic                     cfg_we_i,
  input  logic [AbW-1:0]           cfg_wdata_i,
  output logic                     result_valid_o,
  output logic signed [SumW-1:0]   func_value_o,
  output logic [PointW-1:0]        inverse_point_o
);

  // coefficient store with per-entry valid bits
  logic [CoeffW-1:0]   coeff_mem [TblDepth];
  logic [TblDepth-1:0] vld_q;
  logic [CoeffW-1:0]   mem_rdata_q;
  logic                mem_vbit_q;

  state_e            state_q, state_d;
  opcode_e           op_q, op_d;
  logic [AbW-1:0]    active_bits_q;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic [IdxW-1:0]   last_q, last_d;
  logic [IdxW-1:0]   point_q, point_d;
  logic [IdxW-1:0]   lo_q, lo_d;
  logic [IdxW-1:0]   hi_q, hi_d;
  logic signed [31:0] target_q, target_d;
  logic signed [SumW-1:0] acc_q, acc_d;
  logic              rd_vld_q, rd_vld_d;
  logic              rd_inc_q, rd_inc_d;

  logic              res_valid_q, res_valid_d;
  logic signed [SumW-1:0] res_func_q, res_func_d;
  logic [PointW-1:0] res_inv_q, res_inv_d;

  logic              accept;
  logic              mem_we;
  logic [AbW-1:0]    ab_eff;
  logic [IdxW-1:0]   last_idx;
  logic [IdxW-1:0]   lo_n, hi_n;
  logic signed [SumW-1:0] term;
  logic signed [SumW-1:0] target_ext;

  assign accept = start && !busy;
  assign busy   = (state_q != StIdle);
  assign mem_we = accept && (opcode_e'(opcode_i) == OpWrite);

  // active table size, clamped to the store depth
  assign ab_eff   = (32'(active_bits_q) > MaxBits) ? AbW'(MaxBits) : active_bits_q;
  assign last_idx = ~({IdxW{1'b1}} << ab_eff);

  // read data of a never-written entry counts as zero
  assign term = mem_vbit_q ? {{(SumW-CoeffW){mem_rdata_q[CoeffW-1]}}, mem_rdata_q}
                           : '0;
  assign target_ext = {{(SumW-32){target_q[31]}}, target_q};

  // memory write port and registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      coeff_mem[IdxW'(entry_index_i)] <= coeff_value_i;
    end
    mem_rdata_q <= coeff_mem[idx_q];
  end

  // valid bits and valid read-out
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q      <= '0;
      mem_vbit_q <= 1'b0;
    end else begin
      if (mem_we) begin
        vld_q[IdxW'(entry_index_i)] <= 1'b1;
      end
      mem_vbit_q <= vld_q[idx_q];
    end
  end

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_bits_q <= AbW'(MaxBits);
    end else if (cfg_we_i) begin
      active_bits_q <= cfg_wdata_i;
    end
  end

  // control and datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      op_q        <= OpEval;
      rd_vld_q    <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      rd_vld_q    <= rd_vld_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    last_q     <= last_d;
    point_q    <= point_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    target_q   <= target_d;
    acc_q      <= acc_d;
    rd_inc_q   <= rd_inc_d;
    res_func_q <= res_func_d;
    res_inv_q  <= res_inv_d;
  end

  // next search bounds after one walk
  always_comb begin
    lo_n = lo_q;
    hi_n = hi_q;
    if (acc_q <= target_ext) begin
      lo_n = point_q;
    end else begin
      hi_n = point_q - {{(IdxW-1){1'b0}}, 1'b1};
    end
  end

  // sequencer: next state, walk control, accumulation and result
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    idx_d       = idx_q;
    last_d      = last_q;
    point_d     = point_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    target_d    = target_q;
    acc_d       = acc_q;
    rd_vld_d    = 1'b0;
    rd_inc_d    = 1'b0;
    res_valid_d = 1'b0;
    res_func_d  = res_func_q;
    res_inv_d   = res_inv_q;

    // accumulate the entry read in the previous cycle
    if (rd_vld_q && rd_inc_q) begin
      acc_d = acc_q + term;
    end

    case (state_q)
      StIdle: begin
        if (accept) begin
          last_d   = last_idx;
          target_d = target_i;
          idx_d    = '0;
          acc_d    = '0;
          case (opcode_e'(opcode_i))
            OpEval: begin
              op_d    = OpEval;
              point_d = IdxW'(point_i);
              state_d = StWalk;
            end
            OpInverse: begin
              op_d = OpInverse;
              lo_d = '0;
              hi_d = last_idx;
              if (last_idx != '0) begin
                // first midpoint of the full range
                point_d = IdxW'((32'(last_idx) + 1) >> 1);
                state_d = StWalk;
              end else begin
                res_valid_d = 1'b1;
                res_func_d  = '0;
                res_inv_d   = '0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      StWalk: begin
        // issue one read per cycle, flag entries that are subsets of the point
        rd_vld_d = 1'b1;
        rd_inc_d = ((idx_q & ~point_q) == '0);
        idx_d    = idx_q + {{(IdxW-1){1'b0}}, 1'b1};
        if (idx_q == last_q) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        // last read data lands in the accumulator
        state_d = StFinish;
      end
      StFinish: begin
        if (op_q == OpEval) begin
          res_valid_d = 1'b1;
          res_func_d  = acc_q;
          res_inv_d   = '0;
          state_d     = StIdle;
        end else begin
          lo_d = lo_n;
          hi_d = hi_n;
          if (lo_n < hi_n) begin
            point_d = IdxW'(({1'b0, lo_n} + {1'b0, hi_n} + {{IdxW{1'b0}}, 1'b1}) >> 1);
            idx_d   = '0;
            acc_d   = '0;
            state_d = StWalk;
          end else begin
            res_valid_d = 1'b1;
            res_func_d  = '0;
            res_inv_d   = PointW'(lo_n);
            state_d     = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign result_valid_o  = res_valid_q;
  assign func_value_o    = res_func_q;
  assign inverse_point_o = res_inv_q;

endmodule

/* verif/moment_table_eval_and_inverse_top_tb.sv */
`timescale 1ns / 1ps

module moment_table_eval_and_inverse_top_tb;
  import mtei_pkg::*;

  localparam logic [1:0] OpUnused = 2'd3;
  localparam int ClkHalf = 6;
  localparam int ResetCycles = 9;
  localparam int DrainCycles = 24;
  localparam int IdlePct = 7;
  localparam logic signed [CoeffW-1:0] CoeffMax = 32'sh7FFF_FFFF;
  localparam logic signed [CoeffW-1:0] CoeffMin = 32'sh8000_0000;

  typedef struct {
    logic [1:0]               op;
    logic [IdxW-1:0]          entry_index;
    logic signed [CoeffW-1:0] coeff;
    logic [PointW-1:0]        point;
    logic signed [31:0]       target;
  } cmd_t;

  typedef struct {
    logic signed [SumW-1:0] func_value;
    logic [PointW-1:0]      inv_point;
  } answer_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic [1:0]               opcode_i = '0;
  logic [7:0]               entry_index_i = '0;
  logic signed [CoeffW-1:0] coeff_value_i = '0;
  logic [PointW-1:0]        point_i = '0;
  logic signed [31:0]       target_i = '0;
  logic                     cfg_we_i = 1'b0;
  logic [AbW-1:0]           cfg_wdata_i = '0;
  logic                     result_valid_o;
  logic signed [SumW-1:0]   func_value_o;
  logic [PointW-1:0]        inverse_point_o;

  // pending commands and predicted answers
  cmd_t    cmd_queue[$];
  cmd_t    cur_cmd;
  answer_t expected_answers[$];
  answer_t head_ans;

  // predictor state
  logic signed [CoeffW-1:0] coef_tbl [TblDepth];
  logic [AbW-1:0]           act_bits;

  bit              calm = 1'b0;
  int              error_cnt = 0;
  int              item_cnt = 0;
  int unsigned     idle_roll;
  longint unsigned cycle_cnt = 0;
  longint unsigned cycle_budget = 200000;

  // clock
  always #(ClkHalf) clk_i = ~clk_i;

  moment_table_eval_and_inverse_top u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .opcode_i        (opcode_i),
    .entry_index_i   (entry_index_i),
    .coeff_value_i   (coeff_value_i),
    .point_i         (point_i),
    .target_i        (target_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .result_valid_o  (result_valid_o),
    .func_value_o    (func_value_o),
    .inverse_point_o (inverse_point_o)
  );

  // ---------------- predictor ----------------

  function automatic int unsigned span_bits();
    return (act_bits > MaxBits) ? MaxBits : act_bits;
  endfunction

  function automatic int unsigned table_span();
    return 1 << span_bits();
  endfunction

  // sum of every coefficient whose index is a subset of x
  function automatic longint moment_sum(int unsigned x, int unsigned span);
    longint acc;
    acc = 0;
    for (int unsigned i = 0; i < span; i++)
      if ((i & ~x) == 0) acc += longint'(coef_tbl[i]);
    return acc;
  endfunction

  // fixed-step binary search for the largest point whose sum is not above y
  function automatic int unsigned inverse_search(logic signed [31:0] y, int unsigned span);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    lo = 0;
    hi = span - 1;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      if (moment_sum(mid, span) <= longint'(y)) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  task automatic predict(cmd_t c);
    answer_t     a;
    longint      acc;
    int unsigned span;
    span = table_span();
    case (c.op)
      OpWrite: coef_tbl[c.entry_index] = c.coeff;
      OpEval: begin
        acc = moment_sum(c.point, span);
        a.func_value = acc[SumW-1:0];
        a.inv_point = '0;
        expected_answers.push_back(a);
      end
      OpInverse: begin
        a.func_value = '0;
        a.inv_point = PointW'(inverse_search(c.target, span));
        expected_answers.push_back(a);
      end
      default: ;
    endcase
  endtask

  // ---------------- stimulus helpers ----------------

  function automatic cmd_t rand_cmd(logic [1:0] op);
    cmd_t c;
    c.op = op;
    c.entry_index = IdxW'($urandom);
    c.coeff = $urandom;
    c.point = PointW'($urandom);
    c.target = $urandom;
    return c;
  endfunction

  function automatic logic signed [CoeffW-1:0] pick_coeff();
    case ($urandom_range(0, 9))
      0: return CoeffMax;
      1: return CoeffMin;
      2: return '0;
      3: return -1;
      default: return $urandom;
    endcase
  endfunction

  task automatic push_cmd(cmd_t c);
    int unsigned span;
    span = table_span();
    cmd_queue.push_back(c);
    if (c.op == OpEval || c.op == OpInverse)
      cycle_budget += (span_bits() + 1) * (span + 8) + 16;
    else
      cycle_budget += 8;
    if (c.op != OpUnused) item_cnt++;
  endtask

  task automatic write_entry(int unsigned idx, logic signed [CoeffW-1:0] v);
    cmd_t c;
    c = rand_cmd(OpWrite);
    c.entry_index = idx[IdxW-1:0];
    c.coeff = v;
    push_cmd(c);
  endtask

  task automatic eval_at_point(logic [PointW-1:0] p);
    cmd_t c;
    c = rand_cmd(OpEval);
    c.point = p;
    push_cmd(c);
  endtask

  task automatic search_target(logic signed [31:0] t);
    cmd_t c;
    c = rand_cmd(OpInverse);
    c.target = t;
    push_cmd(c);
  endtask

  // superincreasing single-bit weights give a monotone function
  task automatic monotone_seq();
    int unsigned span;
    int unsigned nb;
    int unsigned mult;
    int unsigned x;
    longint      c0;
    longint      run;
    longint      fx;
    longint      t;
    longint      w [MaxBits];
    span = table_span();
    nb = span_bits();
    c0 = longint'($signed($urandom)) >>> 1;
    mult = $urandom_range(1, 4000);
    run = 0;
    for (int unsigned k = 0; k < nb; k++) begin
      w[k] = (run + longint'($urandom_range(0, 1000))) * longint'(mult);
      run += w[k] / longint'(mult);
    end
    for (int unsigned i = 0; i < span; i++) begin
      if (i == 0) write_entry(i, c0[31:0]);
      else if ($onehot(i)) write_entry(i, w[$clog2(i)][31:0]);
      else write_entry(i, '0);
    end
    repeat ($urandom_range(3, 10)) begin
      if ($urandom_range(0, 2) == 0) begin
        eval_at_point(PointW'($urandom));
      end else begin
        x = $urandom_range(0, span - 1);
        fx = c0;
        for (int unsigned k = 0; k < nb; k++)
          if (x[k]) fx += w[k];
        case ($urandom_range(0, 4))
          0: t = fx;
          1: t = fx - 1;
          2: t = fx + 1;
          3: t = c0 - 1 - longint'($urandom_range(0, 1000));
          default: t = longint'($signed($urandom));
        endcase
        search_target(t[31:0]);
      end
    end
  endtask

  // whole active table at an extreme, for the widest sums
  task automatic extreme_fill();
    int unsigned span;
    int unsigned kind;
    span = table_span();
    kind = $urandom_range(0, 2);
    for (int unsigned i = 0; i < span; i++) begin
      case (kind)
        0: write_entry(i, CoeffMax);
        1: write_entry(i, CoeffMin);
        default: write_entry(i, i[0] ? CoeffMax : CoeffMin);
      endcase
    end
    eval_at_point(8'hFF);
    eval_at_point(PointW'($urandom));
    search_target($urandom);
    search_target(CoeffMax);
  endtask

  task automatic mixed_seq();
    cmd_t c;
    repeat ($urandom_range(5, 20)) begin
      c = rand_cmd(2'($urandom_range(0, 2)));
      c.coeff = pick_coeff();
      push_cmd(c);
    end
  endtask

  task automatic noise_seq();
    repeat ($urandom_range(2, 6)) begin
      if ($urandom_range(0, 1) == 0) push_cmd(rand_cmd(OpUnused));
      else write_entry($urandom_range(0, TblDepth - 1), pick_coeff());
    end
  endtask

  task automatic random_phase(int n);
    int          goal;
    int unsigned roll;
    goal = item_cnt + n;
    while (item_cnt < goal) begin
      roll = $urandom_range(0, 99);
      if (roll < 55) monotone_seq();
      else if (roll < 70) extreme_fill();
      else if (roll < 90) mixed_seq();
      else noise_seq();
    end
  endtask

  // wait until nothing is pending or in flight
  task automatic settle();
    do @(negedge clk_i);
    while (cmd_queue.size() != 0 || start || expected_answers.size() != 0 || busy);
    repeat (DrainCycles) @(posedge clk_i);
    cycle_budget += DrainCycles + 64;
  endtask

  task automatic set_bits(logic [AbW-1:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    act_bits = v;
  endtask

  // ---------------- driver ----------------

  // present the next command once the current transfer is done
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) predict(cur_cmd);
      if (!start || !busy) begin
        idle_roll = $urandom_range(0, 99);
        if (cmd_queue.size() != 0 && (calm || idle_roll >= IdlePct)) begin
          cur_cmd = cmd_queue.pop_front();
          start <= 1'b1;
          opcode_i <= cur_cmd.op;
          entry_index_i <= cur_cmd.entry_index;
          coeff_value_i <= cur_cmd.coeff;
          point_i <= cur_cmd.point;
          target_i <= cur_cmd.target;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // ---------------- monitor ----------------

  // compare each result transfer with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (expected_answers.size() == 0) begin
        error_cnt++;
        $display("%0t: unexpected result: expected none, actual func_value %0d inverse_point %0d",
                 $time, func_value_o, inverse_point_o);
      end else begin
        head_ans = expected_answers.pop_front();
        if (func_value_o !== head_ans.func_value) begin
          error_cnt++;
          $display("%0t: func_value mismatch: expected %0d actual %0d",
                   $time, head_ans.func_value, func_value_o);
        end
        if (inverse_point_o !== head_ans.inv_point) begin
          error_cnt++;
          $display("%0t: inverse_point mismatch: expected %0d actual %0d",
                   $time, head_ans.inv_point, inverse_point_o);
        end
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > 4 * cycle_budget) begin
      $display("FAIL moment_table_eval_and_inverse_top");
      $finish;
    end
  end

  // ---------------- sequence ----------------

  int unsigned phase_bits [10] = '{0, 1, 2, 3, 4, 5, 6, 7, 8, 15};
  int          phase_len  [10] = '{50, 100, 150, 180, 120, 120, 100, 50, 150, 30};

  initial begin
    act_bits = 4'd8;
    foreach (coef_tbl[i]) coef_tbl[i] = '0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    // cleared table at reset width
    eval_at_point(8'h00);
    eval_at_point(8'hFF);
    search_target(0);
    search_target(-1);
    write_entry(0, CoeffMax);
    write_entry(255, CoeffMin);
    write_entry(1, -1);
    write_entry(128, 5);
    eval_at_point(8'hFF);
    eval_at_point(8'h00);
    eval_at_point(8'h81);
    eval_at_point(8'hAA);
    push_cmd(rand_cmd(OpUnused));
    search_target(CoeffMax);
    search_target(CoeffMin);
    settle();

    // single-entry table, write outside the active range
    set_bits(4'd0);
    eval_at_point(8'hFF);
    search_target(0);
    write_entry(3, 9);
    eval_at_point(8'h03);
    settle();

    // width above the table size acts as full width
    set_bits(4'd15);
    eval_at_point(8'hFF);
    search_target(0);

    foreach (phase_bits[p]) begin
      settle();
      set_bits(phase_bits[p][AbW-1:0]);
      calm = (phase_bits[p] == 4);
      if (phase_bits[p] == 3) begin
        random_phase(phase_len[p] / 2);
        settle();
        random_phase(phase_len[p] / 2);
      end else begin
        random_phase(phase_len[p]);
      end
    end
    settle();

    if (error_cnt == 0) begin
      $display("PASS moment_table_eval_and_inverse_top");
    end else begin
      $display("FAIL moment_table_eval_and_inverse_top");
    end
    $finish;
  end

endmodule
